/* hdl/owrs_pkg.sv */
// Shared types and constants for the 1-Wire ROM search controller.
package owrs_pkg;

	localparam int MAX_PASSES = 100;
	localparam int ID_BITS    = 64;
	localparam int POS_W      = $clog2(ID_BITS);

	localparam logic [7:0] CMD_SEARCH_ALL   = 8'hF0;
	localparam logic [7:0] CMD_SEARCH_ALARM = 8'hEC;

	// Triplet status with neither id nor complement bit pulled low.
	localparam logic [1:0] TRIP_NO_RESPONSE = 2'b11;

	typedef enum logic [1:0] {
		EV_START      = 2'd0,
		EV_RESET_DONE = 2'd1,
		EV_BYTE_DONE  = 2'd2,
		EV_TRIP_DONE  = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		ACT_RESET   = 2'd0,
		ACT_WRITE   = 2'd1,
		ACT_TRIPLET = 2'd2,
		ACT_FINISH  = 2'd3
	} action_t;

endpackage

/* hdl/one_wire_rom_search.sv */
// 1-Wire ROM search controller: maps bus events to the next bus request.
//
// Each request on the slave side reports one bus event (search start, reset
// done with presence, command byte written, triplet done with its 3-bit
// status) and produces exactly one request on the master side: bus reset,
// write the search command byte (0xF0, or 0xEC for an alarm search), run a
// triplet with a given direction, or search finished. The result that closes
// a full 64-bit pass also carries the identifier found. The block takes one
// event per clock while answers are taken; an event is held in an input
// register, decided combinationally against the search state, and its answer
// is loaded into the output register once that register is free. The output
// register frees the input side, so a stalled answer does not block the next
// event until both registers are full. Searching stops after the last device,
// when no device answers a reset, or once MAX_PASSES passes have begun; a
// failed pass keeps its partial path as the guide for the next one.
module one_wire_rom_search
	import owrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] alarm_only, [1] presence, [4:2] triplet_result
	input  logic [1:0]  s_tuser,   // [1:0] opcode

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [7:0] command_byte, [8] direction, [72:9] found_id
	output logic [2:0]  m_tuser    // [1:0] action, [2] found_valid
);

	// input register
	logic        valid_s1;
	event_t      op_s1;
	logic        alarm_s1;
	logic        pres_s1;
	logic [2:0]  trip_s1;

	// search state
	logic [ID_BITS-1:0] prev_path_q;
	logic [ID_BITS-1:0] cur_id_q;
	logic signed [7:0]  branch_q;     // 64 before the first pass, -1 when no branch left
	logic signed [7:0]  last_zero_q;  // -1 when no zero taken at a discrepancy
	logic [POS_W-1:0]   bit_pos_q;
	logic               last_dev_q;
	logic [6:0]         pass_cnt_q;
	logic               alarm_mode_q;

	// next state
	logic [ID_BITS-1:0] prev_path_d;
	logic [ID_BITS-1:0] cur_id_d;
	logic signed [7:0]  branch_d;
	logic signed [7:0]  last_zero_d;
	logic [POS_W-1:0]   bit_pos_d;
	logic               last_dev_d;
	logic [6:0]         pass_cnt_d;
	logic               alarm_mode_d;

	// result
	action_t            act_d;
	logic [7:0]         cmd_d;
	logic               dir_d;
	logic               found_d;
	logic [ID_BITS-1:0] found_id_d;
	logic               try_pass;
	logic [POS_W-1:0]   pos_next;

	logic out_free;
	logic advance;

	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// direction rule: 1 at the branch point, 0 past it, else follow the last path
	function automatic logic pick_dir(input logic [POS_W-1:0] pos,
			input logic signed [7:0] branch, input logic [ID_BITS-1:0] path);
		logic signed [7:0] p;
		p = signed'({2'b00, pos});
		if (p == branch)
			return 1'b1;
		else if (p > branch)
			return 1'b0;
		else
			return path[pos];
	endfunction

	assign pos_next = bit_pos_q + POS_W'(1);

	always_comb begin
		prev_path_d  = prev_path_q;
		cur_id_d     = cur_id_q;
		branch_d     = branch_q;
		last_zero_d  = last_zero_q;
		bit_pos_d    = bit_pos_q;
		last_dev_d   = last_dev_q;
		pass_cnt_d   = pass_cnt_q;
		alarm_mode_d = alarm_mode_q;
		act_d        = ACT_FINISH;
		cmd_d        = '0;
		dir_d        = 1'b0;
		found_d      = 1'b0;
		found_id_d   = '0;
		try_pass     = 1'b0;

		case (op_s1)
			EV_START: begin
				alarm_mode_d = alarm_s1;
				prev_path_d  = '0;
				pass_cnt_d   = '0;
				branch_d     = 8'sd64;
				last_zero_d  = -8'sd1;
				last_dev_d   = 1'b0;
				try_pass     = 1'b1;
			end
			EV_RESET_DONE: begin
				if (pres_s1) begin
					cur_id_d  = '0;
					bit_pos_d = '0;
					act_d     = ACT_WRITE;
					cmd_d     = alarm_mode_q ? CMD_SEARCH_ALARM : CMD_SEARCH_ALL;
				end
			end
			EV_BYTE_DONE: begin
				act_d = ACT_TRIPLET;
				dir_d = pick_dir(bit_pos_q, branch_q, prev_path_q);
			end
			EV_TRIP_DONE: begin
				if (trip_s1[1:0] == TRIP_NO_RESPONSE) begin
					// no device answered: keep the partial path, retry
					prev_path_d = cur_id_q;
					bit_pos_d   = '0;
					try_pass    = 1'b1;
				end else begin
					if (trip_s1 == 3'b000)
						last_zero_d = signed'({2'b00, bit_pos_q});
					cur_id_d = cur_id_q | (ID_BITS'(trip_s1[2]) << bit_pos_q);
					if (bit_pos_q == POS_W'(ID_BITS - 1)) begin
						last_dev_d  = (branch_q == last_zero_d) || last_zero_d[7];
						branch_d    = last_zero_d;
						prev_path_d = cur_id_d;
						bit_pos_d   = '0;
						found_d     = 1'b1;
						found_id_d  = cur_id_d;
						try_pass    = 1'b1;
					end else begin
						bit_pos_d = pos_next;
						act_d     = ACT_TRIPLET;
						dir_d     = pick_dir(pos_next, branch_q, prev_path_q);
					end
				end
			end
			default: ;
		endcase

		if (try_pass) begin
			if (!last_dev_d && pass_cnt_d < 7'(MAX_PASSES)) begin
				pass_cnt_d = pass_cnt_d + 7'd1;
				act_d      = ACT_RESET;
			end else begin
				act_d = ACT_FINISH;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= event_t'(s_tuser);
			alarm_s1 <= s_tdata[0];
			pres_s1  <= s_tdata[1];
			trip_s1  <= s_tdata[4:2];
		end
	end

	// search state, updated as each request is decided
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_path_q  <= '0;
			cur_id_q     <= '0;
			branch_q     <= 8'sd64;
			last_zero_q  <= -8'sd1;
			bit_pos_q    <= '0;
			last_dev_q   <= 1'b0;
			pass_cnt_q   <= '0;
			alarm_mode_q <= 1'b0;
		end else if (advance) begin
			prev_path_q  <= prev_path_d;
			cur_id_q     <= cur_id_d;
			branch_q     <= branch_d;
			last_zero_q  <= last_zero_d;
			bit_pos_q    <= bit_pos_d;
			last_dev_q   <= last_dev_d;
			pass_cnt_q   <= pass_cnt_d;
			alarm_mode_q <= alarm_mode_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tuser <= {found_d, act_d};
			m_tdata <= {7'd0, found_id_d, dir_d, cmd_d};
		end
	end

endmodule
